// ===== src/assert_macros.svh =====
// Assertion helpers included by the checker module file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MM_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int IDX_BITS     = 3;
  localparam int DIM_BITS     = 4;
  localparam int OP_BITS      = 2;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [OP_BITS-1:0] OP_WR_A    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_WR_B    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic we_a;
    logic we_b;
  } mem_wr_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
    logic ack;
  } mac_ctl_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] rows_a;
    logic [DIM_BITS-1:0] inner_dim;
    logic [DIM_BITS-1:0] cols_b;
  } dims_t;

endpackage

// ===== src/mm_if.sv =====
`timescale 1ns / 1ps

interface mm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [mm_pkg::OP_BITS-1:0]           opcode;
  logic [mm_pkg::IDX_BITS-1:0]          row_index;
  logic [mm_pkg::IDX_BITS-1:0]          col_index;
  logic signed [mm_pkg::VALUE_BITS-1:0] element_value;

  modport source (output valid, output opcode, output row_index, output col_index,
                  output element_value, input ready);
  modport sink (input valid, input opcode, input row_index, input col_index,
                input element_value, output ready);
endinterface

interface mm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mm_pkg::IDX_BITS-1:0]          out_row;
  logic [mm_pkg::IDX_BITS-1:0]          out_col;
  logic signed [mm_pkg::VALUE_BITS-1:0] product_value;
  logic                                 is_last;

  modport source (output valid, output out_row, output out_col, output product_value,
                  output is_last, input ready);
  modport sink (input valid, input out_row, input out_col, input product_value,
                input is_last, output ready);
endinterface

// ===== src/mm_store.sv =====
`timescale 1ns / 1ps

module mm_store #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  logic                                 clk,
  input  mm_pkg::mem_wr_t                      mem_wr,
  input  logic [AW-1:0]                        wr_addr,
  input  logic signed [mm_pkg::VALUE_BITS-1:0] wr_data,
  input  logic [AW-1:0]                        rd_addr_a,
  input  logic [AW-1:0]                        rd_addr_b,
  output logic signed [mm_pkg::VALUE_BITS-1:0] rd_a,
  output logic signed [mm_pkg::VALUE_BITS-1:0] rd_b
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic signed [mm_pkg::VALUE_BITS-1:0] mem_a [DEPTH];
  logic signed [mm_pkg::VALUE_BITS-1:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_wr.we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (mem_wr.we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

// ===== src/mm_mac.sv =====
`timescale 1ns / 1ps

module mm_mac #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mm_pkg::mac_ctl_t                     ctl,
  input  logic signed [mm_pkg::VALUE_BITS-1:0] op_a,
  input  logic signed [mm_pkg::VALUE_BITS-1:0] op_b,
  output logic                                 done,
  output logic signed [mm_pkg::VALUE_BITS-1:0] result
);

  localparam int VB     = mm_pkg::VALUE_BITS;
  localparam int PROD_W = 2 * VB;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int HI_W   = ACC_W - VB + 1;

  logic                     s1_valid_r, s1_first_r, s1_last_r;
  logic                     s2_valid_r, s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     done_r, done_nxt;
  logic signed [ACC_W-1:0]  shifted;
  logic [HI_W-1:0]          hi_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      s1_valid_r <= ctl.issue;
      s2_valid_r <= s1_valid_r;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= ctl.first;
    s1_last_r  <= ctl.last;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= op_a * op_b;
    acc_r      <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s2_valid_r) begin
      if (s2_first_r) begin
        acc_nxt = ACC_W'(prod_r);
      end else begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (ctl.ack) begin
      done_nxt = 1'b0;
    end
    if (s2_valid_r && s2_last_r) begin
      done_nxt = 1'b1;
    end
  end

  // floor shift, then clamp to the signed word range
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    hi_bits = shifted[ACC_W-1:VB-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      result = shifted[VB-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = {1'b1, {(VB-1){1'b0}}};
    end else begin
      result = {1'b0, {(VB-1){1'b1}}};
    end
  end

  assign done = done_r;

endmodule

// ===== src/mm_seq.sv =====
`timescale 1ns / 1ps

module mm_seq #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mm_in_if.sink                                in_ch,
  mm_out_if.source                             out_ch,
  input  mm_pkg::dims_t                        dims,
  output mm_pkg::mem_wr_t                      mem_wr,
  output logic [AW-1:0]                        wr_addr,
  output logic [AW-1:0]                        rd_addr_a,
  output logic [AW-1:0]                        rd_addr_b,
  output mm_pkg::mac_ctl_t                     mac_ctl,
  input  logic                                 mac_done,
  input  logic signed [mm_pkg::VALUE_BITS-1:0] mac_result
);

  localparam int IB = mm_pkg::IDX_BITS;
  localparam int DB = mm_pkg::DIM_BITS;
  localparam int PW = 2 * IB;

  mm_pkg::state_t state_r, state_nxt;

  logic [IB-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IB-1:0] m_r, m_nxt, n_r, n_nxt, q_r, q_nxt;

  logic                                 out_valid_r;
  logic [IB-1:0]                        out_row_r, out_col_r;
  logic signed [mm_pkg::VALUE_BITS-1:0] out_val_r;
  logic                                 out_last_r;

  logic in_fire, is_compute, wr_in_range, elem_last, load;

  function automatic logic [IB-1:0] last_idx(input logic [DB-1:0] d);
    if (d == '0) begin
      return '0;
    end else if (d > DB'(MAX_DIM)) begin
      return IB'(MAX_DIM - 1);
    end else begin
      return IB'(d - 1'b1);
    end
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IB-1:0] r, input logic [IB-1:0] c);
    logic [PW-1:0] lin;
    lin = PW'(r) * PW'(MAX_DIM) + PW'(c);
    return lin[AW-1:0];
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_compute  = (in_ch.opcode == mm_pkg::OP_COMPUTE);
  assign wr_in_range = ({1'b0, in_ch.row_index} < (IB+1)'(MAX_DIM)) &&
                       ({1'b0, in_ch.col_index} < (IB+1)'(MAX_DIM));
  assign elem_last   = (i_r == m_r) && (j_r == q_r);
  assign load        = (state_r == mm_pkg::ST_FINISH) && mac_done &&
                       (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    m_r <= m_nxt;
    n_r <= n_nxt;
    q_r <= q_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mm_pkg::ST_IDLE: begin
        if (in_fire && is_compute) begin
          state_nxt = mm_pkg::ST_RUN;
        end
      end
      mm_pkg::ST_RUN: begin
        if (k_r == n_r) begin
          state_nxt = mm_pkg::ST_FINISH;
        end
      end
      mm_pkg::ST_FINISH: begin
        if (load) begin
          state_nxt = elem_last ? mm_pkg::ST_IDLE : mm_pkg::ST_RUN;
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    mem_wr      = '0;
    mac_ctl     = '0;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    m_nxt = m_r;
    n_nxt = n_r;
    q_nxt = q_r;
    unique case (state_r)
      mm_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) begin
          unique case (in_ch.opcode)
            mm_pkg::OP_WR_A: mem_wr.we_a = wr_in_range;
            mm_pkg::OP_WR_B: mem_wr.we_b = wr_in_range;
            mm_pkg::OP_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              m_nxt = last_idx(dims.rows_a);
              n_nxt = last_idx(dims.inner_dim);
              q_nxt = last_idx(dims.cols_b);
            end
            default: ;
          endcase
        end
      end
      mm_pkg::ST_RUN: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.first = (k_r == '0);
        mac_ctl.last  = (k_r == n_r);
        k_nxt = (k_r == n_r) ? '0 : k_r + 1'b1;
      end
      mm_pkg::ST_FINISH: begin
        mac_ctl.ack = load;
        if (load) begin
          if (j_r == q_r) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign wr_addr   = addr_of(in_ch.row_index, in_ch.col_index);
  assign rd_addr_a = addr_of(i_r, k_r);
  assign rd_addr_b = addr_of(k_r, j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= i_r;
      out_col_r  <= j_r;
      out_val_r  <= mac_result;
      out_last_r <= elem_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.is_last       = out_last_r;

endmodule

// ===== src/matrix_multiply_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Word                                          Handshake
// in_ch    in   opcode, row_index, col_index, element_value   valid/ready
// out_ch   out  out_row, out_col, product_value, is_last       valid/ready
// cfg_*    in   cfg_index, cfg_wdata                           cfg_wr_en, no stall
//
// Element writes and idle opcodes are accepted back to back while idle.
// For a compute word, one shared multiply-accumulate walks k for each of the
// rows * cols product elements, then the memory read, product and accumulate
// registers drain before that element is loaded.
// in_ch is not ready from compute accept until the last element is loaded.
// A stalled out_ch holds the sequencer once the next element is summed.
// Reset is synchronous; the A and B stores are not cleared.

module matrix_multiply_top #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mm_in_if.sink                             in_ch,
  mm_out_if.source                          out_ch,
  input  logic                              cfg_wr_en,
  input  logic [mm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mm_pkg::DIM_BITS-1:0]       cfg_wdata
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  mm_pkg::dims_t    dims_r;
  mm_pkg::mem_wr_t  mem_wr;
  mm_pkg::mac_ctl_t mac_ctl;

  logic [AW-1:0]                        wr_addr, rd_addr_a, rd_addr_b;
  logic signed [mm_pkg::VALUE_BITS-1:0] rd_a, rd_b, mac_result;
  logic                                 mac_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows_a    <= mm_pkg::DIM_RESET;
      dims_r.inner_dim <= mm_pkg::DIM_RESET;
      dims_r.cols_b    <= mm_pkg::DIM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mm_pkg::CFG_ROWS_A:    dims_r.rows_a    <= cfg_wdata;
        mm_pkg::CFG_INNER_DIM: dims_r.inner_dim <= cfg_wdata;
        mm_pkg::CFG_COLS_B:    dims_r.cols_b    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mm_seq #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .dims       (dims_r),
    .mem_wr     (mem_wr),
    .wr_addr    (wr_addr),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .mac_ctl    (mac_ctl),
    .mac_done   (mac_done),
    .mac_result (mac_result)
  );

  mm_store #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_store (
    .clk       (clk),
    .mem_wr    (mem_wr),
    .wr_addr   (wr_addr),
    .wr_data   (in_ch.element_value),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  mm_mac #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .op_a   (rd_a),
    .op_b   (rd_b),
    .done   (mac_done),
    .result (mac_result)
  );

endmodule

// ===== src/mm_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [mm_pkg::OP_BITS-1:0]     in_opcode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_is_last,
  input logic [mm_pkg::VALUE_BITS-1:0]  out_product_value
);

  `MM_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped while stalled")
  `MM_ASSERT_CLK(a_out_stable, out_valid && !out_ready |=> $stable(out_product_value), "out word changed while stalled")
  `MM_ASSERT_CLK(a_busy_after_compute, in_valid && in_ready && in_opcode == mm_pkg::OP_COMPUTE |=> !in_ready, "input ready during compute")
  `MM_ASSERT_CLK(a_last_stable, out_valid && !out_ready |=> $stable(out_is_last), "last flag changed while stalled")
  `MM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_opcode         (in_ch.opcode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_is_last       (out_ch.is_last),
  .out_product_value (out_ch.product_value)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIM       = 8;
  localparam int FRAC_BITS     = 16;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 24;

  localparam logic [mm_pkg::OP_BITS-1:0] OP_NOP = 2'd3;

  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  typedef struct {
    logic [mm_pkg::OP_BITS-1:0]           op;
    logic [mm_pkg::IDX_BITS-1:0]          row;
    logic [mm_pkg::IDX_BITS-1:0]          col;
    logic signed [mm_pkg::VALUE_BITS-1:0] value;
  } mm_word_t;

  typedef struct {
    logic [mm_pkg::IDX_BITS-1:0]          row;
    logic [mm_pkg::IDX_BITS-1:0]          col;
    logic signed [mm_pkg::VALUE_BITS-1:0] value;
    logic                                 last;
  } product_elem_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_wr_en;
  logic [mm_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [mm_pkg::DIM_BITS-1:0]     cfg_wdata;

  mm_in_if  in_ch ();
  mm_out_if out_ch ();

  matrix_multiply_top #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  mm_word_t      word_q[$];
  product_elem_t product_q[$];
  mm_word_t      next_word;

  // predictor state
  logic signed [mm_pkg::VALUE_BITS-1:0] a_mem[MAX_DIM][MAX_DIM];
  logic signed [mm_pkg::VALUE_BITS-1:0] b_mem[MAX_DIM][MAX_DIM];
  logic [mm_pkg::DIM_BITS-1:0]          rows_cfg, inner_cfg, cols_cfg;

  // entries already queued for writing, so no compute reads an unwritten one
  bit a_known[MAX_DIM][MAX_DIM];
  bit b_known[MAX_DIM][MAX_DIM];

  int src_idle_pct;
  int dst_idle_pct;
  bit in_fire;
  bit hold_armed;
  bit hold_served;
  int hold_left;

  int err_cnt;
  int words_taken;
  int elems_checked;
  int products_run;

  function automatic int eff_dim(logic [mm_pkg::DIM_BITS-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic predict_product();
    int m, n, q;
    logic signed [127:0] acc, pa, pb;
    product_elem_t e;
    m = eff_dim(rows_cfg);
    n = eff_dim(inner_cfg);
    q = eff_dim(cols_cfg);
    products_run++;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < q; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          pa = a_mem[i][k];
          pb = b_mem[k][j];
          acc = acc + pa * pb;
        end
        acc = acc >>> FRAC_BITS;
        e.row = mm_pkg::IDX_BITS'(i);
        e.col = mm_pkg::IDX_BITS'(j);
        if (acc > Q_MAX) e.value = Q_MAX[mm_pkg::VALUE_BITS-1:0];
        else if (acc < Q_MIN) e.value = Q_MIN[mm_pkg::VALUE_BITS-1:0];
        else e.value = acc[mm_pkg::VALUE_BITS-1:0];
        e.last = (i == m - 1) && (j == q - 1);
        product_q.insert(product_q.size(), e);
      end
    end
  endtask

  task automatic apply_word(logic [mm_pkg::OP_BITS-1:0] op,
                            logic [mm_pkg::IDX_BITS-1:0] row,
                            logic [mm_pkg::IDX_BITS-1:0] col,
                            logic signed [mm_pkg::VALUE_BITS-1:0] value);
    case (op)
      mm_pkg::OP_WR_A:    a_mem[row][col] = value;
      mm_pkg::OP_WR_B:    b_mem[row][col] = value;
      mm_pkg::OP_COMPUTE: predict_product();
      default:            ;
    endcase
  endtask

  task automatic apply_cfg(logic [mm_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mm_pkg::DIM_BITS-1:0] data);
    case (idx)
      mm_pkg::CFG_ROWS_A:    rows_cfg = data;
      mm_pkg::CFG_INNER_DIM: inner_cfg = data;
      mm_pkg::CFG_COLS_B:    cols_cfg = data;
      default:               ;
    endcase
  endtask

  task automatic check_elem(logic [mm_pkg::IDX_BITS-1:0] row,
                            logic [mm_pkg::IDX_BITS-1:0] col,
                            logic signed [mm_pkg::VALUE_BITS-1:0] value, logic last);
    product_elem_t want;
    if (product_q.size() == 0) begin
      report_mismatch($sformatf("unexpected element (%0d,%0d) value %h", row, col, value));
      return;
    end
    want = product_q.pop_front();
    elems_checked++;
    if (row !== want.row)
      report_mismatch($sformatf("out_row got %0d want %0d", row, want.row));
    if (col !== want.col)
      report_mismatch($sformatf("out_col got %0d want %0d", col, want.col));
    if (value !== want.value)
      report_mismatch($sformatf("product_value (%0d,%0d) got %h want %h",
                                want.row, want.col, value, want.value));
    if (last !== want.last)
      report_mismatch($sformatf("is_last (%0d,%0d) got %b want %b",
                                want.row, want.col, last, want.last));
  endtask

  // monitor: config, accepted words and results, all sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire   <= 1'b0;
      rows_cfg  = mm_pkg::DIM_RESET;
      inner_cfg = mm_pkg::DIM_RESET;
      cols_cfg  = mm_pkg::DIM_RESET;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (cfg_wr_en) apply_cfg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        words_taken++;
        apply_word(in_ch.opcode, in_ch.row_index, in_ch.col_index, in_ch.element_value);
      end
      if (out_ch.valid && out_ch.ready)
        check_elem(out_ch.out_row, out_ch.out_col, out_ch.product_value, out_ch.is_last);
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_word = word_q.pop_front();
        in_ch.opcode        <= next_word.op;
        in_ch.row_index     <= next_word.row;
        in_ch.col_index     <= next_word.col;
        in_ch.element_value <= next_word.value;
        in_ch.valid         <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_armed && !hold_served && out_ch.valid) begin
      out_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_served  <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  function automatic logic signed [mm_pkg::VALUE_BITS-1:0] random_value();
    int pick;
    logic [19:0] narrow;
    pick   = $urandom_range(9);
    narrow = 20'($urandom);
    if (pick < 4) return $urandom;
    if (pick < 8) return {{12{narrow[19]}}, narrow};
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_0000;
    endcase
  endfunction

  task automatic push_word(logic [mm_pkg::OP_BITS-1:0] op, int row, int col,
                           logic signed [mm_pkg::VALUE_BITS-1:0] value);
    mm_word_t w;
    w.op    = op;
    w.row   = mm_pkg::IDX_BITS'(row);
    w.col   = mm_pkg::IDX_BITS'(col);
    w.value = value;
    if (op == mm_pkg::OP_WR_A) a_known[row][col] = 1'b1;
    else if (op == mm_pkg::OP_WR_B) b_known[row][col] = 1'b1;
    word_q.insert(word_q.size(), w);
  endtask

  task automatic push_compute(int m, int n, int q);
    for (int i = 0; i < m; i++)
      for (int k = 0; k < n; k++)
        if (!a_known[i][k]) push_word(mm_pkg::OP_WR_A, i, k, random_value());
    for (int k = 0; k < n; k++)
      for (int j = 0; j < q; j++)
        if (!b_known[k][j]) push_word(mm_pkg::OP_WR_B, k, j, random_value());
    push_word(mm_pkg::OP_COMPUTE, $urandom_range(7), $urandom_range(7), $urandom);
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (word_q.size() != 0 || in_ch.valid || product_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(logic [mm_pkg::DIM_BITS-1:0] rows,
                            logic [mm_pkg::DIM_BITS-1:0] inner,
                            logic [mm_pkg::DIM_BITS-1:0] cols);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= mm_pkg::CFG_ROWS_A;
    cfg_wdata <= rows;
    @(negedge clk);
    cfg_index <= mm_pkg::CFG_INNER_DIM;
    cfg_wdata <= inner;
    @(negedge clk);
    cfg_index <= mm_pkg::CFG_COLS_B;
    cfg_wdata <= cols;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(logic [mm_pkg::DIM_BITS-1:0] rows,
                           logic [mm_pkg::DIM_BITS-1:0] inner,
                           logic [mm_pkg::DIM_BITS-1:0] cols, int count, bit lead_compute);
    int m, n, q, pick;
    m = eff_dim(rows);
    n = eff_dim(inner);
    q = eff_dim(cols);
    write_dims(rows, inner, cols);
    if (lead_compute) push_compute(m, n, q);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 30)
        push_word(mm_pkg::OP_WR_A, $urandom_range(m - 1), $urandom_range(n - 1),
                  random_value());
      else if (pick < 60)
        push_word(mm_pkg::OP_WR_B, $urandom_range(n - 1), $urandom_range(q - 1),
                  random_value());
      else if (pick < 72)
        push_word($urandom_range(1) ? mm_pkg::OP_WR_B : mm_pkg::OP_WR_A,
                  $urandom_range(7), $urandom_range(7), random_value());
      else if (pick < 80)
        push_word(OP_NOP, $urandom_range(7), $urandom_range(7), $urandom);
      else
        push_compute(m, n, q);
    end
    push_compute(m, n, q);
    wait_idle();
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = mm_pkg::CFG_ROWS_A;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_NOP;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;
    out_ch.ready        = 1'b0;
    src_idle_pct        = 27;
    dst_idle_pct        = 69;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // 1x1x1: saturation both ways, floor on a negative lsb, ignored fields
    write_dims(4'd1, 4'd1, 4'd1);
    push_word(mm_pkg::OP_WR_A, 0, 0, 32'h7fff_ffff);
    push_word(mm_pkg::OP_WR_B, 0, 0, 32'h7fff_ffff);
    push_word(mm_pkg::OP_COMPUTE, 0, 0, 32'h0000_0000);
    push_word(mm_pkg::OP_WR_B, 0, 0, 32'h8000_0000);
    push_word(mm_pkg::OP_COMPUTE, 7, 0, 32'h7fff_ffff);
    push_word(mm_pkg::OP_WR_A, 0, 0, 32'h8000_0000);
    push_word(mm_pkg::OP_COMPUTE, 0, 7, 32'h8000_0000);
    push_word(mm_pkg::OP_WR_A, 7, 7, random_value());
    push_word(mm_pkg::OP_WR_B, 7, 7, random_value());
    push_word(OP_NOP, 7, 7, 32'h8000_0000);
    push_word(OP_NOP, 0, 0, 32'h7fff_ffff);
    push_word(mm_pkg::OP_WR_A, 0, 0, 32'h0000_0001);
    push_word(mm_pkg::OP_WR_B, 0, 0, 32'hffff_ffff);
    push_word(mm_pkg::OP_COMPUTE, 7, 7, 32'hffff_ffff);
    push_word(mm_pkg::OP_WR_B, 0, 0, 32'h0001_8000);
    push_word(mm_pkg::OP_COMPUTE, 3, 5, 32'h1234_5678);
    wait_idle();

    // zero dimensions behave as one
    run_phase(4'd0, 4'd0, 4'd0, 2, 1'b0);
    run_phase(4'd2, 4'd3, 4'd4, 6, 1'b0);
    hold_armed = 1'b1;
    run_phase(4'd8, 4'd1, 4'd8, 6, 1'b1);

    src_idle_pct = 69;
    dst_idle_pct = 27;
    run_phase(4'd3, 4'd8, 4'd2, 6, 1'b0);
    // inner above the maximum clamps to eight
    run_phase(4'd1, 4'd9, 4'd1, 6, 1'b0);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    // rows and cols above the maximum clamp to eight
    run_phase(4'd15, 4'd1, 4'd12, 6, 1'b0);
    run_phase(4'd5, 4'd2, 4'd7, 6, 1'b0);
    run_phase(4'd0, 4'd4, 4'd1, 6, 1'b0);

    $display("Covered %0d input words, %0d multiplies and %0d checked product elements,",
             words_taken, products_run, elems_checked);
    $display("shapes from 1x1x1 up to 8 per side incl. zero and clamped dims, saturation, stalls.");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d words queued, %0d elements outstanding",
             word_q.size(), product_q.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
